// ===== hw/rtl/register_mapped_calculator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the register-mapped calculator
// Shared wrappers for clocked properties with reset disable.
// ----------------------------------------------------------------------------
`ifndef REGISTER_MAPPED_CALCULATOR_TOP_DEFINES_SVH
`define REGISTER_MAPPED_CALCULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmc_pkg
// Types, register map and codes of the register-mapped calculator.
// ----------------------------------------------------------------------------
package rmc_pkg;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 12;
  localparam int OP_W      = 2;
  localparam int WORD_W    = ADDR_W - 2;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int REG_COUNT = 6;

  localparam logic [ADDR_W-1:0] REG_BYTES  = ADDR_W'(REG_COUNT * 4);
  localparam logic [CNT_W-1:0]  STEP_LAST  = CNT_W'(DATA_W - 1);

  // Transfer kinds
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Register word indices
  localparam logic [WORD_W-1:0] IDX_OPERATOR = 10'd0;
  localparam logic [WORD_W-1:0] IDX_OPA      = 10'd1;
  localparam logic [WORD_W-1:0] IDX_OPB      = 10'd2;
  localparam logic [WORD_W-1:0] IDX_CONTROL  = 10'd3;
  localparam logic [WORD_W-1:0] IDX_STATUS   = 10'd4;
  localparam logic [WORD_W-1:0] IDX_RESULT   = 10'd5;
  localparam logic [WORD_W-1:0] ID_FIRST     = 10'h3F8;
  localparam logic [WORD_W-1:0] ID_LAST      = 10'h3FF;

  // Operator codes (low bits; upper bits must be zero)
  localparam logic [1:0] OPC_ADD = 2'd0;
  localparam logic [1:0] OPC_SUB = 2'd1;
  localparam logic [1:0] OPC_MUL = 2'd2;
  localparam logic [1:0] OPC_DIV = 2'd3;

  // Control commands
  localparam logic [DATA_W-1:0] CTL_IDLE  = 32'd0;
  localparam logic [DATA_W-1:0] CTL_GO    = 32'd1;
  localparam logic [DATA_W-1:0] CTL_CLRI  = 32'd2;
  localparam logic [DATA_W-1:0] CTL_ABORT = 32'd3;

  localparam logic [7:0] ID_BYTES [8] = '{8'h11, 8'h10, 8'h88, 8'h08,
                                          8'h0d, 8'hf0, 8'h05, 8'hb1};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } rmc_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              ok;
    logic              irq;
  } rmc_out_t;

  typedef struct packed {
    logic       start;
    logic [1:0] opc;
    logic       known;
  } rmc_alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } rmc_alu_rsp_t;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_RUN,
    ALU_DONE
  } rmc_alu_state_e;

  typedef enum logic {
    ST_ACCEPT,
    ST_CALC
  } rmc_state_e;

endpackage

// ===== hw/rtl/rmc_alu.sv =====
// ----------------------------------------------------------------------------
// rmc_alu
// Iterative arithmetic unit: one shared 33-bit adder serves add, subtract,
// shift-add multiply and restoring divide; the last two take one bit a cycle.
// ----------------------------------------------------------------------------
module rmc_alu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rmc_pkg::rmc_alu_req_t       req_i,
  input  logic [rmc_pkg::DATA_W-1:0]  a_i,
  input  logic [rmc_pkg::DATA_W-1:0]  b_i,
  output rmc_pkg::rmc_alu_rsp_t       rsp_o
);
  import rmc_pkg::*;

  rmc_alu_state_e    state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] mcand_q, mcand_d;
  logic [DATA_W-1:0] mplier_q, mplier_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [1:0]        op_q, op_d;

  logic [DATA_W:0]   add_x, add_y;
  logic              add_sub;
  logic [DATA_W+1:0] add_sum;
  logic              no_borrow;
  logic              b_zero;

  assign b_zero = (b_i == '0);

  // Shared adder operand selection
  always_comb begin
    add_x   = {1'b0, a_i};
    add_y   = {1'b0, b_i};
    add_sub = (req_i.opc == OPC_SUB);
    if (state_q == ALU_RUN) begin
      if (op_q == OPC_DIV) begin
        add_x   = {acc_q, mplier_q[DATA_W-1]};
        add_y   = {1'b0, mcand_q};
        add_sub = 1'b1;
      end else begin
        add_x   = {1'b0, acc_q};
        add_y   = {1'b0, mcand_q};
        add_sub = 1'b0;
      end
    end
  end

  assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                   + (DATA_W+2)'(add_sub);
  assign no_borrow = add_sum[DATA_W+1];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          if (req_i.known && ((req_i.opc == OPC_MUL) ||
                              ((req_i.opc == OPC_DIV) && !b_zero))) begin
            state_d = ALU_RUN;
          end else begin
            state_d = ALU_DONE;
          end
        end
      end
      ALU_RUN: begin
        if (cnt_q == STEP_LAST) begin
          state_d = ALU_DONE;
        end
      end
      ALU_DONE: state_d = ALU_IDLE;
      default:  state_d = ALU_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    res_d    = res_q;
    op_d     = op_q;
    case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.opc;
          cnt_d = '0;
          acc_d = '0;
          case (req_i.opc)
            OPC_ADD, OPC_SUB: res_d = add_sum[DATA_W-1:0];
            OPC_MUL: begin
              mcand_d  = a_i;
              mplier_d = b_i;
            end
            OPC_DIV: begin
              mcand_d  = b_i;
              mplier_d = a_i;
              res_d    = '0;
            end
            default: res_d = '0;
          endcase
          if (!req_i.known) begin
            res_d = '0;
          end
        end
      end
      ALU_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (op_q == OPC_DIV) begin
          // Restoring step: keep the difference when it does not borrow
          acc_d    = no_borrow ? add_sum[DATA_W-1:0]
                               : {acc_q[DATA_W-2:0], mplier_q[DATA_W-1]};
          mplier_d = {mplier_q[DATA_W-2:0], no_borrow};
          if (cnt_q == STEP_LAST) begin
            res_d = {mplier_q[DATA_W-2:0], no_borrow};
          end
        end else begin
          acc_d    = mplier_q[0] ? add_sum[DATA_W-1:0] : acc_q;
          mcand_d  = {mcand_q[DATA_W-2:0], 1'b0};
          mplier_d = {1'b0, mplier_q[DATA_W-1:1]};
          if (cnt_q == STEP_LAST) begin
            res_d = mplier_q[0] ? add_sum[DATA_W-1:0] : acc_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    rsp_o.done   = (state_q == ALU_DONE);
    rsp_o.result = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    res_q    <= res_d;
    op_q     <= op_d;
  end

endmodule

// ===== hw/rtl/register_mapped_calculator_top.sv =====
// ----------------------------------------------------------------------------
// register_mapped_calculator_top
// Bus-attached 32-bit calculator with operator, operand, control, status and
// result registers, an ID block and an interrupt level.
// ----------------------------------------------------------------------------
// Usage
//   The input channel carries one transfer per item: a bus read, a bus write
//   or a calculator tick. Every item gives exactly one result on the output
//   channel: read data, an ok flag and the interrupt level after the item.
//   Reads, writes and ticks that do not compute load their result into the
//   output register, where it sits from the next cycle on.
//   A computing tick (busy, first phase, no abort) hands the operands to the
//   iterative unit: add, sub, unknown codes and divide by zero go straight to
//   its done state; mul and div first make the 32 one-bit steps through the
//   shared adder. No new item is taken until the unit's result has been loaded
//   into the output register.
//   A new item is taken whenever no computation is in flight and the output
//   register is empty or is being drained in the same cycle; a stalled result
//   holds the input off.
//   Reset clears the register file, the interrupt and the status to idle, and
//   leaves the output channel empty.
// ----------------------------------------------------------------------------
module register_mapped_calculator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rmc_pkg::rmc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rmc_pkg::rmc_out_t out_data_o
);
  import rmc_pkg::*;

  rmc_state_e        state_q, state_d;
  logic [DATA_W-1:0] operator_q, operator_d;
  logic [DATA_W-1:0] opa_q, opa_d;
  logic [DATA_W-1:0] opb_q, opb_d;
  logic [DATA_W-1:0] ctl_q, ctl_d;
  logic [DATA_W-1:0] result_q, result_d;
  logic              busy_q, busy_d;
  logic              phase_q, phase_d;
  logic              irq_q, irq_d;
  logic              out_valid_q, out_valid_d;
  rmc_out_t          out_data_q, out_data_d;

  logic              in_acc;
  logic              out_free;
  logic              compute;
  logic [WORD_W-1:0] word;
  logic              in_regs;
  logic              in_id;
  logic [DATA_W-1:0] reg_rdata;

  rmc_alu_req_t      alu_req;
  rmc_alu_rsp_t      alu_rsp;

  // Take a new item only when no computation runs and the output register will be free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_ACCEPT) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign word    = in_data_i.addr[ADDR_W-1:2];
  assign in_regs = (in_data_i.addr < REG_BYTES);
  assign in_id   = (word >= ID_FIRST) && (word <= ID_LAST);

  // A tick that must run the arithmetic unit before it can answer
  assign compute = in_acc && (in_data_i.op == OP_TICK) && busy_q &&
                   (ctl_q != CTL_ABORT) && !phase_q;

  always_comb begin
    case (word)
      IDX_OPERATOR: reg_rdata = operator_q;
      IDX_OPA:      reg_rdata = opa_q;
      IDX_OPB:      reg_rdata = opb_q;
      IDX_CONTROL:  reg_rdata = ctl_q;
      IDX_STATUS:   reg_rdata = {{(DATA_W-1){1'b0}}, busy_q};
      IDX_RESULT:   reg_rdata = result_q;
      default:      reg_rdata = '0;
    endcase
  end

  always_comb begin
    alu_req.start = compute;
    alu_req.opc   = operator_q[1:0];
    alu_req.known = (operator_q[DATA_W-1:2] == '0);
  end

  rmc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (opa_q),
    .b_i    (opb_q),
    .rsp_o  (alu_rsp)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCEPT: if (compute)      state_d = ST_CALC;
      ST_CALC:   if (alu_rsp.done) state_d = ST_ACCEPT;
      default:   state_d = ST_ACCEPT;
    endcase
  end

  // Register file, tick control and result formation
  always_comb begin
    operator_d  = operator_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    ctl_d       = ctl_q;
    result_d    = result_q;
    busy_d      = busy_q;
    phase_d     = phase_q;
    irq_d       = irq_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (in_acc) begin
      out_data_d.rdata = '0;
      out_data_d.ok    = 1'b0;
      case (in_data_i.op)
        OP_READ: begin
          if (in_regs) begin
            out_data_d.rdata = reg_rdata;
            out_data_d.ok    = 1'b1;
          end else if (in_id) begin
            out_data_d.rdata = {{(DATA_W-8){1'b0}}, ID_BYTES[word[2:0]]};
            out_data_d.ok    = 1'b1;
          end
        end
        OP_WRITE: begin
          if (in_regs) begin
            out_data_d.ok = 1'b1;
            case (word)
              IDX_OPERATOR: operator_d = in_data_i.wdata;
              IDX_OPA:      opa_d      = in_data_i.wdata;
              IDX_OPB:      opb_d      = in_data_i.wdata;
              IDX_CONTROL:  ctl_d      = in_data_i.wdata;
              default:      out_data_d.ok = 1'b0;
            endcase
          end
        end
        OP_TICK: begin
          out_data_d.ok = 1'b1;
          if (!busy_q) begin
            if (ctl_q == CTL_GO) begin
              irq_d   = 1'b0;
              phase_d = 1'b0;
              busy_d  = 1'b1;
            end else if (ctl_q == CTL_CLRI) begin
              irq_d = 1'b0;
            end
          end else if (ctl_q == CTL_ABORT) begin
            phase_d = 1'b0;
            busy_d  = 1'b0;
          end else if (!phase_q) begin
            phase_d = 1'b1;
          end else begin
            irq_d   = 1'b1;
            busy_d  = 1'b0;
            phase_d = 1'b0;
          end
          ctl_d = CTL_IDLE;
        end
        default: ;
      endcase
      out_data_d.irq = irq_d;
      // Hold the result back on a computing tick until the unit finishes
      if (!compute) begin
        out_valid_d = 1'b1;
      end
    end

    if ((state_q == ST_CALC) && alu_rsp.done) begin
      result_d         = alu_rsp.result;
      out_data_d.rdata = '0;
      out_data_d.ok    = 1'b1;
      out_data_d.irq   = irq_q;
      out_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCEPT;
      operator_q  <= '0;
      opa_q       <= '0;
      opb_q       <= '0;
      ctl_q       <= CTL_IDLE;
      result_q    <= '0;
      busy_q      <= 1'b0;
      phase_q     <= 1'b0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      operator_q  <= operator_d;
      opa_q       <= opa_d;
      opb_q       <= opb_d;
      ctl_q       <= ctl_d;
      result_q    <= result_d;
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      irq_q       <= irq_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; advance only on load
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/rmc_checker.sv =====
// ----------------------------------------------------------------------------
// rmc_port_checker
// Port-level checks on the calculator, bound to the top level.
// ----------------------------------------------------------------------------
`include "register_mapped_calculator_top_defines.svh"

module rmc_port_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input rmc_pkg::rmc_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rmc_pkg::rmc_out_t out_data_o
);
  import rmc_pkg::*;

  // A stalled input transfer is held by the sender
  `RMC_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(in_data_i), "stalled input changed")

  // A stalled result keeps its transfer steady
  `RMC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // No item is taken while a finished result is held off
  `RMC_ASSERT_NOW(a_no_accept_when_full, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o, "input taken while output blocked")

  // A failed access returns zero data
  `RMC_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, out_valid_o && !out_data_o.ok, out_data_o.rdata == '0, "failed access with nonzero data")

endmodule

bind register_mapped_calculator_top rmc_port_checker u_rmc_checker (.*);
